@@ hdl/bpr_pkg.sv @@
// Shared widths, codes and types for the bounded permutation rearranger.
package bpr_pkg;

  localparam int MAX_LEN   = 16;
  localparam int MIN_LEN   = 2;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int POS_W     = 5;
  localparam int VAL_W     = 6;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [VAL_W-1:0] entry_t;
  typedef logic [MODE_W-1:0]       mode_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam mode_t MODE_IDENT = 2'd0;
  localparam mode_t MODE_REV   = 2'd1;
  localparam mode_t MODE_TRANS = 2'd2;
  localparam mode_t MODE_EMIT  = 2'd3;

  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_REJ = 2'd1;
  localparam status_t ST_BAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_BOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED     = 2'd2;

  localparam logic [CFG_W-1:0] RST_SEQ_LENGTH   = 5'd15;
  localparam logic [CFG_W-1:0] RST_LAMBDA_BOUND = 5'd2;

endpackage

@@ hdl/bpr_if.sv @@
// Word channels into and out of the rearranger.
interface bpr_in_if;
  import bpr_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  pos_t  first_pos;
  pos_t  mid_pos;
  pos_t  end_pos;
  modport source (output valid, output mode, output first_pos, output mid_pos,
                  output end_pos, input ready);
  modport sink (input valid, input mode, input first_pos, input mid_pos,
                input end_pos, output ready);
endinterface

interface bpr_out_if;
  import bpr_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  pos_t    position;
  entry_t  entry_value;
  logic    last;
  logic    all_within_lambda;
  modport source (output valid, output status, output position, output entry_value,
                  output last, output all_within_lambda, input ready);
  modport sink (input valid, input status, input position, input entry_value,
                input last, input all_within_lambda, output ready);
endinterface

@@ hdl/bpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bpr_disp_check.sv @@
// Shared displacement checker: | |value| - position | < lambda.
module bpr_disp_check (
  input  bpr_pkg::entry_t           value,
  input  bpr_pkg::pos_t             pos,
  input  logic [bpr_pkg::CFG_W-1:0] lambda,
  output logic                      ok
);
  import bpr_pkg::*;

  logic signed [VAL_W:0]   v_ext;
  logic        [VAL_W:0]   mag;
  logic signed [VAL_W+1:0] diff;
  logic        [VAL_W+1:0] gap;

  always_comb begin
    v_ext = {value[VAL_W-1], value};
    mag   = v_ext[VAL_W] ? (VAL_W+1)'(-v_ext) : (VAL_W+1)'(v_ext);
    diff  = $signed({1'b0, mag}) - $signed((VAL_W+2)'(pos));
    gap   = diff[VAL_W+1] ? (VAL_W+2)'(-diff) : (VAL_W+2)'(diff);
    ok    = gap < (VAL_W+2)'(lambda);
  end

endmodule

@@ hdl/bounded_permutation_rearranger.sv @@
// Bounded permutation rearranger. A small sequencer walks the touched positions
// through one permutation RAM read port and one shared displacement checker.
// Identity load and rejected operands go straight to the finish word; a reversal or
// transposition runs a build pass into the scratch RAM, then a commit pass back; an
// emit runs a check pass, then one read and one output word per position.
// The input is not ready until the sequencer is back in idle; a finished word
// may still sit in the output register while the next input is taken.
module bounded_permutation_rearranger (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpr_pkg::CFG_W-1:0]     cfg_data,
  bpr_in_if.sink                        in_ch,
  bpr_out_if.source                     out_ch
);
  import bpr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BUILD  = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [CFG_W-1:0] seq_length;
  logic [CFG_W-1:0] lambda_bound;
  logic             unsigned_mode;

  logic [2:0]   state;
  mode_t        mode_q;
  pos_t         i_q, j_q, k_q, hi_q, n_q, cnt, rd_pos;
  logic         issuing, rd_vld, ok_acc;
  status_t      res_status;
  logic [MAX_LEN-1:0] vld;

  logic         o_valid;
  status_t      o_status;
  pos_t         o_pos;
  entry_t       o_val;
  logic         o_last, o_ok;

  logic              in_fire, out_free, last_rd, chk_ok, rev_bad, trans_bad;
  pos_t              n_eff, lim, src_pos;
  logic [POS_W:0]    split;
  logic [ADDR_W-1:0] perm_raddr, perm_raddr_q, rd_addr, cnt_addr;
  logic              perm_hit_q, perm_we, scratch_we;
  entry_t            perm_rdata, scratch_rdata, perm_val, cand, chk_val;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_free = !o_valid || out_ch.ready;
  assign last_rd  = rd_vld && !issuing;

  always_comb begin
    if (seq_length < CFG_W'(MIN_LEN)) n_eff = POS_W'(MIN_LEN);
    else if (seq_length > CFG_W'(MAX_LEN)) n_eff = POS_W'(MAX_LEN);
    else n_eff = POS_W'(seq_length);
  end

  always_comb begin
    rev_bad = (in_ch.first_pos == '0) || (in_ch.first_pos > in_ch.mid_pos) ||
              (in_ch.mid_pos > n_eff) ||
              (({1'b0, in_ch.mid_pos} - {1'b0, in_ch.first_pos} + (POS_W+1)'(1)) >
               (POS_W+1)'(lambda_bound));
    trans_bad = (in_ch.first_pos == '0) || (in_ch.first_pos >= in_ch.mid_pos) ||
                (in_ch.mid_pos >= in_ch.end_pos) ||
                ({1'b0, in_ch.end_pos} > ({1'b0, n_eff} + (POS_W+1)'(1))) ||
                (({1'b0, in_ch.end_pos} - {1'b0, in_ch.first_pos}) >
                 (POS_W+1)'(lambda_bound));
  end

  // source position of the candidate entry at position cnt
  always_comb begin
    split = {1'b0, i_q} + {1'b0, k_q} - {1'b0, j_q};
    if (mode_q == MODE_REV) begin
      src_pos = POS_W'({1'b0, i_q} + {1'b0, j_q} - {1'b0, cnt});
    end else if ({1'b0, cnt} < split) begin
      src_pos = POS_W'({1'b0, cnt} + {1'b0, j_q} - {1'b0, i_q});
    end else begin
      src_pos = POS_W'({1'b0, cnt} - {1'b0, k_q} + {1'b0, j_q});
    end
  end

  assign cnt_addr   = ADDR_W'(cnt - POS_W'(1));
  assign rd_addr    = ADDR_W'(rd_pos - POS_W'(1));
  assign perm_raddr = (state == S_BUILD) ? ADDR_W'(src_pos - POS_W'(1)) : cnt_addr;
  assign perm_we    = (state == S_COMMIT) && rd_vld;
  assign scratch_we = (state == S_BUILD) && rd_vld;

  always_ff @(posedge clk) begin
    perm_raddr_q <= perm_raddr;
    perm_hit_q   <= vld[perm_raddr];
  end

  // entries never written since identity load read as their own position
  assign perm_val = perm_hit_q ? perm_rdata
                               : entry_t'({1'b0, perm_raddr_q}) + entry_t'(1);
  assign cand     = (mode_q == MODE_REV && !unsigned_mode) ? entry_t'(-perm_val)
                                                           : perm_val;
  assign chk_val  = (state == S_BUILD) ? cand : perm_val;
  assign lim      = (state == S_SCAN) ? n_q : hi_q;

  bpr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_perm (
    .clk   (clk),
    .we    (perm_we),
    .waddr (rd_addr),
    .wdata (scratch_rdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  bpr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_scratch (
    .clk   (clk),
    .we    (scratch_we),
    .waddr (rd_addr),
    .wdata (cand),
    .raddr (cnt_addr),
    .rdata (scratch_rdata)
  );

  bpr_disp_check u_check (
    .value  (chk_val),
    .pos    (rd_pos),
    .lambda (lambda_bound),
    .ok     (chk_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length    <= RST_SEQ_LENGTH;
      lambda_bound  <= RST_LAMBDA_BOUND;
      unsigned_mode <= 1'b1;
      state         <= S_IDLE;
      issuing       <= 1'b0;
      rd_vld        <= 1'b0;
      o_valid       <= 1'b0;
      vld           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEQ_LENGTH:   seq_length    <= cfg_data;
          CFG_LAMBDA_BOUND: lambda_bound  <= cfg_data;
          CFG_UNSIGNED:     unsigned_mode <= cfg_data[0];
          default: ;
        endcase
      end

      if (o_valid && out_ch.ready) begin
        o_valid <= 1'b0;
      end

      if (perm_we) begin
        vld[rd_addr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            mode_q <= in_ch.mode;
            i_q    <= in_ch.first_pos;
            j_q    <= in_ch.mid_pos;
            k_q    <= in_ch.end_pos;
            n_q    <= n_eff;
            ok_acc <= 1'b1;
            case (in_ch.mode)
              MODE_IDENT: begin
                vld        <= '0;
                res_status <= ST_OK;
                state      <= S_FINISH;
              end
              MODE_EMIT: begin
                cnt     <= POS_W'(1);
                issuing <= 1'b1;
                state   <= S_SCAN;
              end
              MODE_REV, MODE_TRANS: begin
                if ((in_ch.mode == MODE_REV) ? rev_bad : trans_bad) begin
                  res_status <= ST_BAD;
                  state      <= S_FINISH;
                end else begin
                  cnt     <= in_ch.first_pos;
                  hi_q    <= (in_ch.mode == MODE_REV) ? in_ch.mid_pos
                                                      : in_ch.end_pos - POS_W'(1);
                  issuing <= 1'b1;
                  state   <= S_BUILD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_BUILD, S_COMMIT, S_SCAN: begin
          rd_vld <= issuing;
          rd_pos <= cnt;
          if (issuing) begin
            if (cnt == lim) issuing <= 1'b0;
            else cnt <= cnt + POS_W'(1);
          end
          if (rd_vld && state != S_COMMIT) begin
            ok_acc <= ok_acc && chk_ok;
          end
          if (last_rd) begin
            case (state)
              S_BUILD: begin
                if (ok_acc && chk_ok) begin
                  cnt     <= i_q;
                  issuing <= 1'b1;
                  state   <= S_COMMIT;
                end else begin
                  res_status <= ST_REJ;
                  state      <= S_FINISH;
                end
              end
              S_COMMIT: begin
                res_status <= ST_OK;
                state      <= S_FINISH;
              end
              default: begin
                cnt   <= POS_W'(1);
                state <= S_EMIT;
              end
            endcase
          end
        end

        S_EMIT: begin
          if (!rd_vld) begin
            rd_vld <= 1'b1;
          end else if (out_free) begin
            o_valid  <= 1'b1;
            o_status <= ST_OK;
            o_pos    <= cnt;
            o_val    <= perm_val;
            o_last   <= (cnt == n_q);
            o_ok     <= ok_acc;
            rd_vld   <= 1'b0;
            if (cnt == n_q) state <= S_IDLE;
            else cnt <= cnt + POS_W'(1);
          end
        end

        S_FINISH: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_status <= res_status;
            o_pos    <= '0;
            o_val    <= '0;
            o_last   <= 1'b1;
            o_ok     <= 1'b0;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = o_valid;
  assign out_ch.status            = o_status;
  assign out_ch.position          = o_pos;
  assign out_ch.entry_value       = o_val;
  assign out_ch.last              = o_last;
  assign out_ch.all_within_lambda = o_ok;

  a_ident_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.mode == MODE_IDENT |=> vld == '0)
    else $error("identity load left entries marked written");

  a_commit_after_pass: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |-> ok_acc)
    else $error("commit pass entered without a passing check");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && rd_vld |-> cnt >= POS_W'(1) && cnt <= n_q)
    else $error("emit position out of range");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !issuing && !rd_vld)
    else $error("reads in flight while taking a new word");

endmodule
